@@ rtl/bprct_pkg.sv @@
// Shared types and constants for the button press, repeat and chord tracker.
// Depends on nothing; every other file of the block imports it.

package bprct_pkg;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_DRAIN   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KEY_PWR    = 3'd0,
    KEY_TOGGLE = 3'd1,
    KEY_NEXT   = 3'd2,
    KEY_PREV   = 3'd3,
    KEY_VUP    = 3'd4,
    KEY_VDOWN  = 3'd5,
    KEY_OTHER  = 3'd6
  } key_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_CHORD_ENABLE    = 3'd0;
  localparam cfg_idx_t REG_VOLUME_STEP     = 3'd1;
  localparam cfg_idx_t REG_REPEAT_DELAY    = 3'd2;
  localparam cfg_idx_t REG_REPEAT_INTERVAL = 3'd3;
  localparam cfg_idx_t REG_LONG_PRESS_TIME = 3'd4;
  localparam cfg_idx_t REG_SEEK_HOLD_TIME  = 3'd5;
  localparam cfg_idx_t REG_SEEK_INTERVAL   = 3'd6;
  localparam cfg_idx_t REG_CHORD_WINDOW    = 3'd7;

  typedef struct packed {
    logic        chord_enable;
    logic [6:0]  volume_step;
    logic [15:0] repeat_delay;
    logic [15:0] repeat_interval;
    logic [15:0] long_press_time;
    logic [15:0] seek_hold_time;
    logic [15:0] seek_interval;
    logic [15:0] chord_window;
  } cfg_t;

  typedef struct packed {
    logic        power_tap;
    logic        power_long;
    logic        screenshot;
    logic        next_press;
    logic        prev_press;
    logic [7:0]  play_count;
    logic [15:0] volume_change;
    logic [15:0] seek_steps;
    logic        seek_first;
  } result_t;

  // Adds or subtracts one volume step and clamps to the signed 16-bit range.
  function automatic logic [15:0] vol_sat(input logic [15:0] v, input logic [6:0] step,
                                          input logic neg);
    logic signed [17:0] d;
    logic signed [17:0] s;
    d = $signed({11'b0, step});
    if (neg) begin
      d = -d;
    end
    s = $signed({{2{v[15]}}, v}) + d;
    if (s > 18'sd32767) begin
      return 16'h7FFF;
    end else if (s < -18'sd32768) begin
      return 16'h8000;
    end else begin
      return s[15:0];
    end
  endfunction

  // A deadline is due once the wrapping difference from it is non-negative.
  function automatic logic is_due(input logic [31:0] now, input logic [31:0] due);
    logic [31:0] diff;
    diff = now - due;
    return ~diff[31];
  endfunction

endpackage

@@ rtl/button_press_repeat_chord_tracker_core.sv @@
// Top level of the button press, repeat and chord tracker.
// Depends on bprct_pkg, bprct_cfg_regs, bprct_state and bprct_out_reg.

// The tracker takes one word per clock cycle while the input is not stalled: a
// key press, a key release, a timer tick or a drain, each with a 32-bit
// wrapping millisecond time stamp. An accepted word is captured in the input
// register and then applied to the key state in a single pass of logic; a
// drain's result is loaded into the output register when the drain is
// applied. Only a drain produces a result word; presses, releases and ticks
// produce none. The single result register sets the one case where input
// stalls: a drain cannot be applied while an earlier result still sits unread
// in that register, and the input register then holds it. Configuration
// registers may be written only while the block is idle; they take effect on
// the next word.

module button_press_repeat_chord_tracker_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  bprct_pkg::cfg_idx_t            cfg_index,
  input  logic [bprct_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [2:0]                     in_key,
  input  logic [31:0]                    in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_power_tap,
  output logic                           out_power_long,
  output logic                           out_screenshot,
  output logic                           out_next_press,
  output logic                           out_prev_press,
  output logic [7:0]                     out_play_count,
  output logic signed [15:0]             out_volume_change,
  output logic [15:0]                    out_seek_steps,
  output logic                           out_seek_first
);
  import bprct_pkg::*;

  cfg_t        cfg;
  result_t     cur_res;
  result_t     out_res;

  // Input register.
  logic        in_vld_r;
  op_t         op_r;
  logic [2:0]  key_r;
  logic [31:0] now_r;

  logic        is_drain;
  logic        step_en;

  // A registered word is applied unless it is a drain that would overwrite
  // a result still waiting at the output.
  assign is_drain = (op_r == OP_DRAIN);
  assign step_en  = in_vld_r && (!is_drain || !out_valid || out_ready);
  assign in_ready = !in_vld_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= op_t'(in_op);
      key_r <= in_key;
      now_r <= in_now_ms;
    end
  end

  bprct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bprct_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .op      (op_r),
    .key     (key_r),
    .now_ms  (now_r),
    .cfg     (cfg),
    .res     (cur_res)
  );

  // The drain result is the state before the drain clears it.
  bprct_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && is_drain),
    .res_in    (cur_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (out_res)
  );

  assign out_power_tap     = out_res.power_tap;
  assign out_power_long    = out_res.power_long;
  assign out_screenshot    = out_res.screenshot;
  assign out_next_press    = out_res.next_press;
  assign out_prev_press    = out_res.prev_press;
  assign out_play_count    = out_res.play_count;
  assign out_volume_change = $signed(out_res.volume_change);
  assign out_seek_steps    = out_res.seek_steps;
  assign out_seek_first    = out_res.seek_first;

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && is_drain && out_valid && !out_ready))
    else $error("input stalled without a blocked drain");

  a_drain_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && is_drain) |=> out_valid)
    else $error("applied drain did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_res))
    else $error("waiting result word changed before it was taken");
`endif

endmodule

@@ rtl/bprct_cfg_regs.sv @@
// Configuration register file of the tracker: eight write-only registers.
// Depends on bprct_pkg for the register indexes and the cfg_t bundle.

module bprct_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  bprct_pkg::cfg_idx_t        cfg_index,
  input  logic [bprct_pkg::CfgDataW-1:0] cfg_wdata,
  output bprct_pkg::cfg_t            cfg
);
  import bprct_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chord_enable    <= 1'b0;
      cfg_r.volume_step     <= 7'd1;
      cfg_r.repeat_delay    <= 16'd350;
      cfg_r.repeat_interval <= 16'd60;
      cfg_r.long_press_time <= 16'd700;
      cfg_r.seek_hold_time  <= 16'd400;
      cfg_r.seek_interval   <= 16'd100;
      cfg_r.chord_window    <= 16'd250;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHORD_ENABLE:    cfg_r.chord_enable    <= cfg_wdata[0];
        REG_VOLUME_STEP:     cfg_r.volume_step     <= cfg_wdata[6:0];
        REG_REPEAT_DELAY:    cfg_r.repeat_delay    <= cfg_wdata;
        REG_REPEAT_INTERVAL: cfg_r.repeat_interval <= cfg_wdata;
        REG_LONG_PRESS_TIME: cfg_r.long_press_time <= cfg_wdata;
        REG_SEEK_HOLD_TIME:  cfg_r.seek_hold_time  <= cfg_wdata;
        REG_SEEK_INTERVAL:   cfg_r.seek_interval   <= cfg_wdata;
        REG_CHORD_WINDOW:    cfg_r.chord_window    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/bprct_state.sv @@
// Key tracking state and its combinational update for one registered word.
// Depends on bprct_pkg for op and key codes, cfg_t, result_t and helpers.

module bprct_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  bprct_pkg::op_t    op,
  input  logic [2:0]        key,
  input  logic [31:0]       now_ms,
  input  bprct_pkg::cfg_t   cfg,
  output bprct_pkg::result_t res
);
  import bprct_pkg::*;

  typedef struct packed {
    logic [7:0]  play_acc;
    logic        next_flag;
    logic        prev_flag;
    logic        tap_flag;
    logic        long_flag;
    logic        shot_flag;
    logic [15:0] vol_acc;
    logic        up_held;
    logic        down_held;
    logic [31:0] up_due;
    logic [31:0] down_due;
    logic        down_undoable;
    logic [31:0] down_press_time;
    logic        down_in_chord;
    logic        pwr_held;
    logic        pwr_long_done;
    logic        pwr_in_chord;
    logic [31:0] pwr_due;
    logic        nxt_held;
    logic        seek_started;
    logic [31:0] seek_due;
    logic [15:0] seek_acc;
    logic        seek_first_flag;
  } trk_state_t;

  trk_state_t st_r;
  trk_state_t st_nxt;
  logic [31:0] down_age;
  logic        chord_rev;

  // Power pressed shortly after volume-down: the reverse-order chord.
  assign down_age  = now_ms - st_r.down_press_time;
  assign chord_rev = cfg.chord_enable & st_r.down_held &
                     (down_age <= {16'b0, cfg.chord_window});

  always_comb begin
    st_nxt = st_r;
    unique case (op)
      OP_PRESS: begin
        unique case (key)
          KEY_PWR: begin
            st_nxt.pwr_held      = 1'b1;
            st_nxt.pwr_long_done = 1'b0;
            st_nxt.pwr_in_chord  = chord_rev;
            st_nxt.pwr_due       = chord_rev ? 32'd0 : now_ms + {16'b0, cfg.long_press_time};
            if (chord_rev) begin
              st_nxt.shot_flag     = 1'b1;
              st_nxt.down_in_chord = 1'b1;
              st_nxt.down_held     = 1'b0;
              if (st_r.down_undoable) begin
                st_nxt.vol_acc       = vol_sat(st_r.vol_acc, cfg.volume_step, 1'b0);
                st_nxt.down_undoable = 1'b0;
              end
            end
          end
          KEY_TOGGLE: begin
            if (st_r.play_acc != 8'hFF) begin
              st_nxt.play_acc = st_r.play_acc + 8'd1;
            end
          end
          KEY_NEXT: begin
            st_nxt.nxt_held     = 1'b1;
            st_nxt.seek_started = 1'b0;
            st_nxt.seek_due     = now_ms + {16'b0, cfg.seek_hold_time};
          end
          KEY_PREV: st_nxt.prev_flag = 1'b1;
          KEY_VUP: begin
            st_nxt.vol_acc = vol_sat(st_r.vol_acc, cfg.volume_step, 1'b0);
            st_nxt.up_held = 1'b1;
            st_nxt.up_due  = now_ms + {16'b0, cfg.repeat_delay};
          end
          KEY_VDOWN: begin
            if (cfg.chord_enable && st_r.pwr_held && !st_r.pwr_long_done) begin
              if (!st_r.pwr_in_chord) begin
                st_nxt.shot_flag    = 1'b1;
                st_nxt.pwr_in_chord = 1'b1;
              end
              st_nxt.down_in_chord = 1'b1;
              st_nxt.down_undoable = 1'b0;
              st_nxt.down_held     = 1'b0;
            end else begin
              st_nxt.vol_acc         = vol_sat(st_r.vol_acc, cfg.volume_step, 1'b1);
              st_nxt.down_held       = 1'b1;
              st_nxt.down_press_time = now_ms;
              st_nxt.down_undoable   = 1'b1;
              st_nxt.down_in_chord   = 1'b0;
              st_nxt.down_due        = now_ms + {16'b0, cfg.repeat_delay};
            end
          end
          default: ;
        endcase
      end
      OP_RELEASE: begin
        unique case (key)
          KEY_PWR: begin
            if (st_r.pwr_held && !st_r.pwr_long_done && !st_r.pwr_in_chord) begin
              st_nxt.tap_flag = 1'b1;
            end
            st_nxt.pwr_held     = 1'b0;
            st_nxt.pwr_in_chord = 1'b0;
          end
          KEY_VUP: st_nxt.up_held = 1'b0;
          KEY_VDOWN: begin
            st_nxt.down_held     = 1'b0;
            st_nxt.down_undoable = 1'b0;
            st_nxt.down_in_chord = 1'b0;
          end
          KEY_NEXT: begin
            if (st_r.nxt_held && !st_r.seek_started) begin
              st_nxt.next_flag = 1'b1;
            end
            st_nxt.nxt_held = 1'b0;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        // Up repeat goes first, so both steps saturate in that order.
        if (st_r.up_held && is_due(now_ms, st_r.up_due)) begin
          st_nxt.vol_acc = vol_sat(st_nxt.vol_acc, cfg.volume_step, 1'b0);
          st_nxt.up_due  = now_ms + {16'b0, cfg.repeat_interval};
        end
        if (st_r.down_held && !st_r.down_in_chord && is_due(now_ms, st_r.down_due)) begin
          st_nxt.vol_acc  = vol_sat(st_nxt.vol_acc, cfg.volume_step, 1'b1);
          st_nxt.down_due = now_ms + {16'b0, cfg.repeat_interval};
        end
        if (st_r.pwr_held && !st_r.pwr_long_done && !st_r.pwr_in_chord &&
            is_due(now_ms, st_r.pwr_due)) begin
          st_nxt.pwr_long_done = 1'b1;
          st_nxt.long_flag     = 1'b1;
        end
        if (st_r.nxt_held && is_due(now_ms, st_r.seek_due)) begin
          if (st_r.seek_acc != 16'hFFFF) begin
            st_nxt.seek_acc = st_r.seek_acc + 16'd1;
          end
          if (!st_r.seek_started) begin
            st_nxt.seek_started    = 1'b1;
            st_nxt.seek_first_flag = 1'b1;
          end
          st_nxt.seek_due = now_ms + {16'b0, cfg.seek_interval};
        end
      end
      OP_DRAIN: begin
        st_nxt.tap_flag        = 1'b0;
        st_nxt.long_flag       = 1'b0;
        st_nxt.shot_flag       = 1'b0;
        st_nxt.next_flag       = 1'b0;
        st_nxt.prev_flag       = 1'b0;
        st_nxt.play_acc        = 8'd0;
        st_nxt.vol_acc         = 16'd0;
        st_nxt.down_undoable   = 1'b0;
        st_nxt.seek_acc        = 16'd0;
        st_nxt.seek_first_flag = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    res.power_tap     = st_r.tap_flag;
    res.power_long    = st_r.long_flag;
    res.screenshot    = st_r.shot_flag;
    res.next_press    = st_r.next_flag;
    res.prev_press    = st_r.prev_flag;
    res.play_count    = st_r.play_acc;
    res.volume_change = st_r.vol_acc;
    res.seek_steps    = st_r.seek_acc;
    res.seek_first    = st_r.seek_first_flag;
  end

`ifndef SYNTH
  a_undo_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.down_undoable |-> st_r.down_held)
    else $error("volume-down step undoable while the key is not held");

  a_chord_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.down_in_chord && st_r.down_held))
    else $error("volume-down both in a chord and repeating");

  a_pwr_chord_held: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pwr_in_chord |-> st_r.pwr_held)
    else $error("power chord flag set without power held");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && op == OP_DRAIN) |=>
      (st_r.vol_acc == 16'd0 && st_r.play_acc == 8'd0 && st_r.seek_acc == 16'd0))
    else $error("accumulators not cleared by a drain");
`endif

endmodule

@@ rtl/bprct_out_reg.sv @@
// Result register of the tracker: holds one drain result until it is taken.
// Depends on bprct_pkg for the result_t bundle.

module bprct_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  bprct_pkg::result_t  res_in,
  input  logic                out_ready,
  output logic                out_valid,
  output bprct_pkg::result_t  res_out
);
  import bprct_pkg::*;

  logic    vld_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;

endmodule
